// ===== rtl/core/bmm_pkg.sv =====
package bmm_pkg;

  localparam int MAX_REGIONS   = 32;
  localparam int TAG_ALIGN     = 8;
  localparam int ALIGN_BITS    = $clog2(TAG_ALIGN);
  localparam int HDR_BYTES     = 8;
  localparam int TAG_HDR_BYTES = 8;
  localparam int MAP_HDR_BYTES = 16;
  localparam int ENTRY_MIN     = 24;
  localparam int ENTRY_USED    = 20;
  localparam int ENTRY_IDX_W   = $clog2(ENTRY_USED);
  localparam int REL_W         = ENTRY_IDX_W + 1;
  localparam int WORD_BYTES    = 4;
  localparam int COUNT_W       = 6;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] TYPE_END = 32'd0;
  localparam logic [31:0] TYPE_MAP = 32'd6;

  localparam logic [1:0] ACT_DATA   = 2'd0;
  localparam logic [1:0] ACT_START  = 2'd1;
  localparam logic [1:0] ACT_ABSENT = 2'd2;

  localparam logic KIND_REGION = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef enum logic [1:0] {
    CMD_DATA,
    CMD_START,
    CMD_ABSENT
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_SKIP,
    PH_TSIZE,
    PH_MAPHDR,
    PH_ENTRY
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ABSENT,
    ST_HDR_SMALL,
    ST_TAG_SMALL,
    ST_TAG_OVERRUN,
    ST_MAP_SMALL,
    ST_ENTRY_SMALL,
    ST_NO_MAP
  } status_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] word;
  } cmd_item_t;

  typedef struct packed {
    logic               kind;
    logic [63:0]        base;
    logic [63:0]        length;
    logic [31:0]        rtype;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       first;
    res_t       second;
  } pair_t;

endpackage

// ===== rtl/core/boot_memory_map_parser.sv =====
// Channel  Handshake              Payload
// in       in_valid / in_ready    action, data_word
// out      out_valid / out_ready  kind, region_base, region_length, region_type,
//                                 status, region_count, last
//
// The walk takes one word per cycle while the output stage can load; a word that
// closes an entry and ends the walk gives two results, presented in turn.
// A word's results go from its queue slot through the walk into the output register.
// A four-word queue sits between input and walk, so input keeps flowing while
// the output side stalls; in_ready drops only when the queue is full.
// rst (synchronous) empties the queue and output register and idles the walk.
module boot_memory_map_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   action,
  input  logic [31:0]                  data_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         kind,
  output logic [63:0]                  region_base,
  output logic [63:0]                  region_length,
  output logic [31:0]                  region_type,
  output logic [2:0]                   status,
  output logic [bmm_pkg::COUNT_W-1:0]  region_count,
  output logic                         last
);

  logic               q_valid;
  bmm_pkg::cmd_item_t q_head;
  logic               q_pop;
  logic               can_load;
  logic               pair_load;
  bmm_pkg::pair_t     pair;

  bmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .data_word  (data_word),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bmm_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .can_load   (can_load),
    .pair_load  (pair_load),
    .pair       (pair)
  );

  bmm_out u_out (
    .clk           (clk),
    .rst           (rst),
    .pair_load     (pair_load),
    .pair          (pair),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .region_base   (region_base),
    .region_length (region_length),
    .region_type   (region_type),
    .status        (status),
    .region_count  (region_count),
    .last          (last)
  );

`ifndef ASSERT_OFF
  a_region_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == bmm_pkg::KIND_REGION) |->
      (region_length != '0) && (status == bmm_pkg::ST_OK))
    else $error("region result with zero length or nonzero status");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == bmm_pkg::KIND_DONE) |-> last)
    else $error("done result not marked last");

  a_absent_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == bmm_pkg::KIND_DONE) && (status == bmm_pkg::ST_ABSENT) |->
      (region_count == '0))
    else $error("absent result with nonzero count");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (region_count <= bmm_pkg::COUNT_W'(bmm_pkg::MAX_REGIONS)))
    else $error("region count above limit");
`endif

endmodule

// ===== rtl/core/bmm_front.sv =====
module bmm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           action,
  input  logic [31:0]          data_word,
  input  logic                 pop,
  output logic                 head_valid,
  output bmm_pkg::cmd_item_t   head
);

  logic [bmm_pkg::QPTR_W-1:0] wr_ptr;
  logic [bmm_pkg::QPTR_W-1:0] rd_ptr;
  logic [bmm_pkg::QPTR_W:0]   fill;
  bmm_pkg::cmd_item_t         slots [bmm_pkg::QUEUE_DEPTH];
  bmm_pkg::cmd_t              cmd;
  logic                       keep;
  logic                       push;

  // unused action code is dropped here and never reaches the walk
  always_comb begin
    cmd  = bmm_pkg::CMD_DATA;
    keep = 1'b1;
    case (action)
      bmm_pkg::ACT_DATA:   cmd = bmm_pkg::CMD_DATA;
      bmm_pkg::ACT_START:  cmd = bmm_pkg::CMD_START;
      bmm_pkg::ACT_ABSENT: cmd = bmm_pkg::CMD_ABSENT;
      default:             keep = 1'b0;
    endcase
  end

  assign in_ready   = (fill != (bmm_pkg::QPTR_W + 1)'(bmm_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready && keep;
  assign head_valid = (fill != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].cmd  <= cmd;
      slots[wr_ptr].word <= data_word;
    end
  end

endmodule

// ===== rtl/core/bmm_walk.sv =====
module bmm_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  bmm_pkg::cmd_item_t  head,
  output logic                pop,
  input  logic                can_load,
  output logic                pair_load,
  output bmm_pkg::pair_t      pair
);

  bmm_pkg::phase_t              phase;
  bmm_pkg::phase_t              phase_next;
  logic [29:0]                  widx;
  logic [29:0]                  widx_next;
  logic [31:0]                  total_size;
  logic [31:0]                  total_size_next;
  logic [31:0]                  total_lim;
  logic [31:0]                  total_lim_next;
  logic [31:0]                  tag_start;
  logic [31:0]                  tag_start_next;
  logic [32:0]                  tag_end;
  logic [32:0]                  tag_end_next;
  logic                         is_map;
  logic                         is_map_next;
  logic [31:0]                  entry_start;
  logic [31:0]                  entry_start_next;
  logic [32:0]                  next_start;
  logic [32:0]                  next_start_next;
  logic [31:0]                  ent_bytes;
  logic [31:0]                  ent_bytes_next;
  logic [bmm_pkg::COUNT_W-1:0]  count;
  logic [bmm_pkg::COUNT_W-1:0]  count_next;
  logic [7:0]                   ebuf      [bmm_pkg::ENTRY_USED];
  logic [7:0]                   ebuf_next [bmm_pkg::ENTRY_USED];
  logic [7:0]                   ebuf_new  [bmm_pkg::ENTRY_USED];

  logic [31:0]                  pos;
  logic [32:0]                  tag_sum;
  logic [bmm_pkg::ALIGN_BITS-1:0] pad;
  logic [33:0]                  next_tag;
  logic [32:0]                  first_end;
  logic [33:0]                  room_end;
  logic [32:0]                  u;
  logic                         win;
  logic                         close_hit;
  logic [bmm_pkg::REL_W-1:0]    rel [bmm_pkg::WORD_BYTES];
  logic [63:0]                  base;
  logic [63:0]                  len;
  logic [31:0]                  rtype;

  logic                         emit_region;
  logic                         emit_done;
  bmm_pkg::status_t             done_status;
  bmm_pkg::res_t                region_res;
  bmm_pkg::res_t                done_res;

  assign pos       = {widx, 2'b00};
  assign tag_sum   = {1'b0, tag_start} + {1'b0, head.word};
  assign pad       = bmm_pkg::ALIGN_BITS'(~head.word[bmm_pkg::ALIGN_BITS-1:0] + 1'b1);
  assign next_tag  = {2'b00, tag_start} + {2'b00, head.word} + 34'(pad);
  assign first_end = {1'b0, entry_start} + {1'b0, head.word};
  assign room_end  = {1'b0, next_start} + {2'b00, ent_bytes};

  // u is the entry-relative offset of the last byte of this word
  assign u         = {1'b0, widx, 2'b11} - {1'b0, entry_start};
  assign win       = !u[32] &&
                     (u[31:0] < 32'(bmm_pkg::ENTRY_USED + bmm_pkg::WORD_BYTES - 1));
  assign close_hit = win && (u[bmm_pkg::ENTRY_IDX_W-1:0] >=
                     bmm_pkg::ENTRY_IDX_W'(bmm_pkg::ENTRY_USED - 1));

  // drop each byte of the word into its slot of the entry buffer
  always_comb begin
    ebuf_new = ebuf;
    for (int k = 0; k < bmm_pkg::WORD_BYTES; k++) begin
      rel[k] = bmm_pkg::REL_W'(u[bmm_pkg::ENTRY_IDX_W-1:0]) + bmm_pkg::REL_W'(k)
             - bmm_pkg::REL_W'(bmm_pkg::WORD_BYTES - 1);
      if (win && (rel[k] < bmm_pkg::REL_W'(bmm_pkg::ENTRY_USED))) begin
        ebuf_new[rel[k][bmm_pkg::ENTRY_IDX_W-1:0]] = head.word[8*k +: 8];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      base[8*j +: 8] = ebuf_new[j];
      len[8*j +: 8]  = ebuf_new[8 + j];
    end
    for (int j = 0; j < 4; j++) begin
      rtype[8*j +: 8] = ebuf_new[16 + j];
    end
  end

  always_comb begin
    phase_next       = phase;
    widx_next        = widx;
    total_size_next  = total_size;
    total_lim_next   = total_lim;
    tag_start_next   = tag_start;
    tag_end_next     = tag_end;
    is_map_next      = is_map;
    entry_start_next = entry_start;
    next_start_next  = next_start;
    ent_bytes_next   = ent_bytes;
    count_next       = count;
    ebuf_next        = ebuf;
    emit_region      = 1'b0;
    emit_done        = 1'b0;
    done_status      = bmm_pkg::ST_OK;

    case (head.cmd)
      bmm_pkg::CMD_ABSENT: begin
        count_next  = '0;
        emit_done   = 1'b1;
        done_status = bmm_pkg::ST_ABSENT;
        phase_next  = bmm_pkg::PH_IDLE;
      end
      bmm_pkg::CMD_START: begin
        widx_next       = 30'd1;
        count_next      = '0;
        total_size_next = head.word;
        total_lim_next  = head.word - 32'(bmm_pkg::TAG_HDR_BYTES);
        if (head.word < 32'(bmm_pkg::HDR_BYTES)) begin
          emit_done   = 1'b1;
          done_status = bmm_pkg::ST_HDR_SMALL;
          phase_next  = bmm_pkg::PH_IDLE;
        end else begin
          phase_next = bmm_pkg::PH_HDR;
        end
      end
      default: begin
        widx_next = widx + 1'b1;
        case (phase)
          bmm_pkg::PH_HDR: begin
            if (total_size < 32'(bmm_pkg::HDR_BYTES + bmm_pkg::TAG_HDR_BYTES)) begin
              emit_done   = 1'b1;
              done_status = bmm_pkg::ST_NO_MAP;
              phase_next  = bmm_pkg::PH_IDLE;
            end else begin
              tag_start_next = 32'(bmm_pkg::HDR_BYTES);
              phase_next     = bmm_pkg::PH_SKIP;
            end
          end
          bmm_pkg::PH_SKIP: begin
            // tag starts are word aligned, so only a whole type word can match
            if (pos == tag_start) begin
              is_map_next = (head.word == bmm_pkg::TYPE_MAP);
              if (head.word == bmm_pkg::TYPE_END) begin
                emit_done   = 1'b1;
                done_status = bmm_pkg::ST_NO_MAP;
                phase_next  = bmm_pkg::PH_IDLE;
              end else begin
                phase_next = bmm_pkg::PH_TSIZE;
              end
            end
          end
          bmm_pkg::PH_TSIZE: begin
            if (head.word < 32'(bmm_pkg::TAG_HDR_BYTES)) begin
              emit_done   = 1'b1;
              done_status = bmm_pkg::ST_TAG_SMALL;
              phase_next  = bmm_pkg::PH_IDLE;
            end else if (tag_sum > {1'b0, total_size}) begin
              emit_done   = 1'b1;
              done_status = bmm_pkg::ST_TAG_OVERRUN;
              phase_next  = bmm_pkg::PH_IDLE;
            end else if (is_map) begin
              if (head.word < 32'(bmm_pkg::MAP_HDR_BYTES)) begin
                emit_done   = 1'b1;
                done_status = bmm_pkg::ST_MAP_SMALL;
                phase_next  = bmm_pkg::PH_IDLE;
              end else begin
                tag_end_next     = tag_sum;
                entry_start_next = tag_start + 32'(bmm_pkg::MAP_HDR_BYTES);
                phase_next       = bmm_pkg::PH_MAPHDR;
              end
            end else if (next_tag > {2'b00, total_lim}) begin
              // no room for another tag header
              emit_done   = 1'b1;
              done_status = bmm_pkg::ST_NO_MAP;
              phase_next  = bmm_pkg::PH_IDLE;
            end else begin
              tag_start_next = next_tag[31:0];
              phase_next     = bmm_pkg::PH_SKIP;
            end
          end
          bmm_pkg::PH_MAPHDR: begin
            if (head.word < 32'(bmm_pkg::ENTRY_MIN)) begin
              emit_done   = 1'b1;
              done_status = bmm_pkg::ST_ENTRY_SMALL;
              phase_next  = bmm_pkg::PH_IDLE;
            end else if (first_end > tag_end) begin
              emit_done   = 1'b1;
              done_status = bmm_pkg::ST_OK;
              phase_next  = bmm_pkg::PH_IDLE;
            end else begin
              ent_bytes_next  = head.word;
              next_start_next = first_end;
              phase_next      = bmm_pkg::PH_ENTRY;
            end
          end
          bmm_pkg::PH_ENTRY: begin
            ebuf_next = ebuf_new;
            if (close_hit) begin
              if (len != '0) begin
                count_next  = count + 1'b1;
                emit_region = 1'b1;
              end
              if ((count_next >= bmm_pkg::COUNT_W'(bmm_pkg::MAX_REGIONS)) ||
                  (room_end > {1'b0, tag_end})) begin
                emit_done   = 1'b1;
                done_status = bmm_pkg::ST_OK;
                phase_next  = bmm_pkg::PH_IDLE;
              end else begin
                entry_start_next = next_start[31:0];
                next_start_next  = room_end[32:0];
              end
            end
          end
          default: begin
            // idle: words are ignored
          end
        endcase
      end
    endcase

    region_res.kind   = bmm_pkg::KIND_REGION;
    region_res.base   = base;
    region_res.length = len;
    region_res.rtype  = rtype;
    region_res.status = bmm_pkg::ST_OK;
    region_res.count  = count_next;
    region_res.last   = !emit_done;

    done_res.kind   = bmm_pkg::KIND_DONE;
    done_res.base   = '0;
    done_res.length = '0;
    done_res.rtype  = '0;
    done_res.status = done_status;
    done_res.count  = count_next;
    done_res.last   = 1'b1;

    pair.num    = {1'b0, emit_region} + {1'b0, emit_done};
    pair.first  = emit_region ? region_res : done_res;
    pair.second = done_res;
  end

  // advance when the word gives nothing or the output stage takes its results
  assign pop       = head_valid && ((pair.num == 2'd0) || can_load);
  assign pair_load = head_valid && (pair.num != 2'd0) && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= bmm_pkg::PH_IDLE;
      widx  <= '0;
      count <= '0;
    end else if (pop) begin
      phase <= phase_next;
      widx  <= widx_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      total_size  <= total_size_next;
      total_lim   <= total_lim_next;
      tag_start   <= tag_start_next;
      tag_end     <= tag_end_next;
      is_map      <= is_map_next;
      entry_start <= entry_start_next;
      next_start  <= next_start_next;
      ent_bytes   <= ent_bytes_next;
      ebuf        <= ebuf_next;
    end
  end

endmodule

// ===== rtl/core/bmm_out.sv =====
module bmm_out (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pair_load,
  input  bmm_pkg::pair_t               pair,
  output logic                         can_load,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         kind,
  output logic [63:0]                  region_base,
  output logic [63:0]                  region_length,
  output logic [31:0]                  region_type,
  output logic [2:0]                   status,
  output logic [bmm_pkg::COUNT_W-1:0]  region_count,
  output logic                         last
);

  bmm_pkg::res_t cur;
  bmm_pkg::res_t nxt;
  logic          cur_valid;
  logic          nxt_valid;
  logic          take;

  assign take     = cur_valid && out_ready;
  // the second slot is only ever filled together with the first
  assign can_load = !cur_valid || (out_ready && !nxt_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      nxt_valid <= 1'b0;
    end else if (pair_load) begin
      cur_valid <= 1'b1;
      nxt_valid <= (pair.num == 2'd2);
    end else if (take) begin
      cur_valid <= nxt_valid;
      nxt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_load) begin
      cur <= pair.first;
      nxt <= pair.second;
    end else if (take) begin
      cur <= nxt;
    end
  end

  assign out_valid     = cur_valid;
  assign kind          = cur.kind;
  assign region_base   = cur.base;
  assign region_length = cur.length;
  assign region_type   = cur.rtype;
  assign status        = cur.status;
  assign region_count  = cur.count;
  assign last          = cur.last;

endmodule

// ===== dv/tb_boot_memory_map_parser.sv =====
`timescale 1ns / 100ps

module tb_boot_memory_map_parser;

  typedef struct {
    logic        kind;
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] rtype;
    logic [2:0]  status;
    logic [5:0]  count;
    logic        last;
  } region_rec_t;

  typedef struct {
    bit [1:0]  act;
    bit [31:0] word;
  } word_item_t;

  typedef enum int {
    FL_NONE,
    FL_HDR_SMALL,
    FL_TAG_SMALL,
    FL_TOTAL_CUT,
    FL_MAP_SMALL,
    FL_ENTRY_SMALL,
    FL_NO_MAP
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = 2'd0;
  logic [31:0] data_word = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [63:0] region_base;
  logic [63:0] region_length;
  logic [31:0] region_type;
  logic [2:0]  status;
  logic [bmm_pkg::COUNT_W-1:0] region_count;
  logic        last;

  boot_memory_map_parser dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .data_word     (data_word),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .region_base   (region_base),
    .region_length (region_length),
    .region_type   (region_type),
    .status        (status),
    .region_count  (region_count),
    .last          (last)
  );

  always #1 clk = ~clk;

  // traffic shaping
  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int unsigned idle_tab[4] = '{0, 48, 0, 21};
  int unsigned stall_tab[4] = '{0, 0, 48, 21};
  bit          hold_arm = 1'b0;
  bit          hold_done;
  int unsigned hold_left;

  word_item_t  word_q[$];
  word_item_t  drv_item;
  region_rec_t region_exp_q[$];
  region_rec_t step_res[$];
  region_rec_t want;
  bit [7:0]    img[$];

  int unsigned errors = 0;
  int unsigned stim_words = 0;
  int unsigned n_structs = 0;
  int unsigned n_regions = 0;
  int unsigned n_dones = 0;
  bit [7:0]    status_seen = 8'd0;

  // walk state of the predictor
  bmm_pkg::phase_t walk_phase = bmm_pkg::PH_IDLE;
  bit [31:0]   walk_off, walk_total, walk_tag_start, walk_tag_size;
  bit [31:0]   walk_ent_size, walk_ent_start, walk_etype;
  bit [31:0]   walk_held[4];
  int unsigned walk_count;

  function automatic bit [31:0] merge_byte(bit [31:0] w, bit [31:0] rel, bit [7:0] b);
    bit [31:0] r;
    r = (rel[1:0] == 2'd0) ? 32'd0 : w;
    return r | (32'(b) << (8 * rel[1:0]));
  endfunction

  task automatic walk_clear();
    walk_off = 0;
    walk_total = 0;
    walk_tag_start = 0;
    walk_tag_size = 0;
    walk_ent_size = 0;
    walk_ent_start = 0;
    walk_etype = 0;
    walk_count = 0;
    for (int i = 0; i < 4; i++) walk_held[i] = 0;
  endtask

  task automatic walk_emit(logic k, bit [63:0] b, bit [63:0] len, bit [31:0] t,
                           bmm_pkg::status_t st);
    region_rec_t r;
    if (step_res.size() >= 2) return;
    r.kind = k;
    r.base = b;
    r.length = len;
    r.rtype = t;
    r.status = st;
    r.count = walk_count[5:0];
    r.last = 1'b0;
    step_res.push_back(r);
  endtask

  task automatic walk_finish(bmm_pkg::status_t st);
    walk_emit(bmm_pkg::KIND_DONE, 64'd0, 64'd0, 32'd0, st);
    walk_phase = bmm_pkg::PH_IDLE;
  endtask

  task automatic walk_open_tag(bit [63:0] c);
    if (c + 64'(bmm_pkg::TAG_HDR_BYTES) > 64'(walk_total)) begin
      walk_finish(bmm_pkg::ST_NO_MAP);
    end else begin
      walk_tag_start = c[31:0];
      walk_phase = bmm_pkg::PH_SKIP;
    end
  endtask

  task automatic walk_close_tag();
    bit [63:0] nxt;
    if (walk_tag_size < bmm_pkg::TAG_HDR_BYTES) begin
      walk_finish(bmm_pkg::ST_TAG_SMALL);
    end else if (64'(walk_tag_start) + 64'(walk_tag_size) > 64'(walk_total)) begin
      walk_finish(bmm_pkg::ST_TAG_OVERRUN);
    end else if (walk_held[0] == bmm_pkg::TYPE_MAP) begin
      if (walk_tag_size < bmm_pkg::MAP_HDR_BYTES) walk_finish(bmm_pkg::ST_MAP_SMALL);
      else walk_phase = bmm_pkg::PH_MAPHDR;
    end else begin
      nxt = (64'(walk_tag_size) + 64'(bmm_pkg::TAG_ALIGN - 1)) &
            ~64'(bmm_pkg::TAG_ALIGN - 1);
      walk_open_tag(64'(walk_tag_start) + nxt);
    end
  endtask

  task automatic walk_close_entry();
    bit [63:0] b, len, nxt;
    b = {walk_held[1], walk_held[0]};
    len = {walk_held[3], walk_held[2]};
    nxt = 64'(walk_ent_start) + 64'(walk_ent_size);
    if (len != 64'd0) begin
      walk_count++;
      walk_emit(bmm_pkg::KIND_REGION, b, len, walk_etype, bmm_pkg::ST_OK);
    end
    if (walk_count >= bmm_pkg::MAX_REGIONS ||
        nxt + 64'(walk_ent_size) > 64'(walk_tag_start) + 64'(walk_tag_size)) begin
      walk_finish(bmm_pkg::ST_OK);
    end else begin
      walk_ent_start = nxt[31:0];
    end
  endtask

  task automatic walk_take_byte(bit [7:0] b);
    bit [31:0] pos, rel;
    pos = walk_off;
    walk_off = pos + 1;
    if (walk_phase == bmm_pkg::PH_HDR) begin
      if (pos < 4) begin
        walk_total = merge_byte(walk_total, pos, b);
        if (pos == 3 && walk_total < bmm_pkg::HDR_BYTES) walk_finish(bmm_pkg::ST_HDR_SMALL);
      end else if (pos == 7) begin
        walk_open_tag(64'(bmm_pkg::HDR_BYTES));
      end
      return;
    end
    if (walk_phase == bmm_pkg::PH_SKIP) begin
      if (pos != walk_tag_start) return;
      walk_phase = bmm_pkg::PH_TSIZE;
    end
    if (walk_phase == bmm_pkg::PH_TSIZE) begin
      rel = pos - walk_tag_start;
      if (rel < 4) begin
        walk_held[0] = merge_byte(walk_held[0], rel, b);
        if (rel == 3 && walk_held[0] == bmm_pkg::TYPE_END) walk_finish(bmm_pkg::ST_NO_MAP);
      end else if (rel < 8) begin
        walk_tag_size = merge_byte(walk_tag_size, rel, b);
        if (rel == 7) walk_close_tag();
      end
      return;
    end
    if (walk_phase == bmm_pkg::PH_MAPHDR) begin
      rel = pos - walk_tag_start;
      if (rel >= 8 && rel < 12) begin
        walk_ent_size = merge_byte(walk_ent_size, rel, b);
        if (rel == 11) begin
          if (walk_ent_size < bmm_pkg::ENTRY_MIN) begin
            walk_finish(bmm_pkg::ST_ENTRY_SMALL);
          end else begin
            walk_ent_start = walk_tag_start + bmm_pkg::MAP_HDR_BYTES;
            if (64'(walk_ent_start) + 64'(walk_ent_size) <=
                64'(walk_tag_start) + 64'(walk_tag_size))
              walk_phase = bmm_pkg::PH_ENTRY;
            else
              walk_finish(bmm_pkg::ST_OK);
          end
        end
      end
      return;
    end
    if (walk_phase == bmm_pkg::PH_ENTRY) begin
      if (pos < walk_ent_start) return;
      rel = pos - walk_ent_start;
      if (rel >= bmm_pkg::ENTRY_USED) return;
      if (rel < 16) walk_held[rel[3:2]] = merge_byte(walk_held[rel[3:2]], rel, b);
      else walk_etype = merge_byte(walk_etype, rel, b);
      if (rel == bmm_pkg::ENTRY_USED - 1) walk_close_entry();
    end
  endtask

  task automatic predict_word(bit [1:0] act, bit [31:0] w);
    region_rec_t r;
    step_res.delete();
    if (act == bmm_pkg::ACT_ABSENT) begin
      walk_clear();
      walk_finish(bmm_pkg::ST_ABSENT);
    end else if (act == bmm_pkg::ACT_START ||
                 (act == bmm_pkg::ACT_DATA && walk_phase != bmm_pkg::PH_IDLE)) begin
      if (act == bmm_pkg::ACT_START) begin
        walk_clear();
        walk_phase = bmm_pkg::PH_HDR;
      end
      for (int k = 0; k < 4 && walk_phase != bmm_pkg::PH_IDLE; k++)
        walk_take_byte(w[8*k +: 8]);
    end
    for (int i = 0; i < step_res.size(); i++) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      region_exp_q.push_back(r);
    end
  endtask

  // stimulus building
  task automatic push_word(bit [1:0] act, bit [31:0] w);
    word_item_t it;
    it.act = act;
    it.word = w;
    word_q.push_back(it);
  endtask

  task automatic put_word32(bit [31:0] v);
    for (int i = 0; i < 4; i++) img.push_back(v[8*i +: 8]);
  endtask

  task automatic put_rand_bytes(int unsigned n);
    repeat (n) img.push_back(8'($urandom));
  endtask

  task automatic align_tag();
    while (img.size() % bmm_pkg::TAG_ALIGN != 0) img.push_back(8'($urandom));
  endtask

  task automatic gen_struct(flaw_t flaw, bit cut_short);
    int unsigned n_tags, tsize, esize, msize, n_ent, slack, nw;
    bit [31:0]   w, total;
    bit [63:0]   len;
    img.delete();
    put_word32(32'd0);
    put_word32($urandom);
    n_tags = (flaw == FL_TAG_SMALL) ? $urandom_range(1, 2) : $urandom_range(0, 2);
    for (int i = 0; i < n_tags; i++) begin
      w = ($urandom_range(1) != 0) ? $urandom_range(1, 30) : $urandom;
      if (w == bmm_pkg::TYPE_END || w == bmm_pkg::TYPE_MAP) w = 32'd7;
      if (flaw == FL_TAG_SMALL && i == n_tags - 1) tsize = $urandom_range(0, 7);
      else tsize = $urandom_range(8, 28);
      put_word32(w);
      put_word32(tsize);
      if (tsize > 8) put_rand_bytes(tsize - 8);
      align_tag();
    end
    if (flaw != FL_NO_MAP) begin
      esize = ($urandom_range(1) != 0) ? 24 : $urandom_range(24, 40);
      n_ent = ($urandom_range(11) == 0) ? $urandom_range(34, 40) : $urandom_range(0, 6);
      slack = $urandom_range(0, 7);
      if (flaw == FL_ENTRY_SMALL) esize = $urandom_range(0, 23);
      if (flaw == FL_ENTRY_SMALL || flaw == FL_MAP_SMALL) n_ent = 0;
      msize = bmm_pkg::MAP_HDR_BYTES + n_ent * esize + slack;
      if (flaw == FL_MAP_SMALL) msize = $urandom_range(8, 15);
      put_word32(bmm_pkg::TYPE_MAP);
      put_word32(msize);
      put_word32(esize);
      put_word32($urandom);
      for (int e = 0; e < n_ent; e++) begin
        put_word32($urandom);
        put_word32($urandom);
        case ($urandom_range(4))
          0: len = ($urandom_range(n_ent > 30 ? 4 : 1) == 0) ? 64'd0 : 64'd1;
          1: len = '1;
          default: len = {$urandom, $urandom};
        endcase
        put_word32(len[31:0]);
        put_word32(len[63:32]);
        put_word32($urandom);
        put_rand_bytes(esize - bmm_pkg::ENTRY_USED);
      end
      put_rand_bytes(slack);
      align_tag();
    end
    put_word32(bmm_pkg::TYPE_END);
    put_word32(32'd8);
    total = img.size();
    if (flaw == FL_HDR_SMALL) total = $urandom_range(0, 7);
    else if (flaw == FL_TOTAL_CUT) total = $urandom_range(8, img.size() - 1);
    for (int i = 0; i < 4; i++) img[i] = total[8*i +: 8];
    nw = img.size() / 4;
    // abandon partway; the next start restarts the walk
    if (cut_short) nw = $urandom_range(1, nw);
    for (int i = 0; i < nw; i++)
      push_word(i == 0 ? bmm_pkg::ACT_START : bmm_pkg::ACT_DATA,
                {img[4*i+3], img[4*i+2], img[4*i+1], img[4*i]});
    stim_words += nw;
    n_structs++;
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid || region_exp_q.size() != 0) @(posedge clk);
  endtask

  task automatic chk_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // input driver: hold the item until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        drv_item = word_q.pop_front();
        in_valid <= 1'b1;
        action <= drv_item.act;
        data_word <= drv_item.word;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side: random stalls plus one long hold to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor: predict on accepted words, then check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_word(action, data_word);
      if (out_valid && out_ready) begin
        if (kind === bmm_pkg::KIND_DONE) n_dones++;
        else n_regions++;
        if (region_exp_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0b base %h len %h",
                   $time, kind, region_base, region_length);
          errors++;
        end else begin
          want = region_exp_q.pop_front();
          if (want.kind == bmm_pkg::KIND_DONE) status_seen[want.status] = 1'b1;
          chk_field("kind", 64'(want.kind), 64'(kind));
          chk_field("region_base", want.base, region_base);
          chk_field("region_length", want.length, region_length);
          chk_field("region_type", 64'(want.rtype), 64'(region_type));
          chk_field("status", 64'(want.status), 64'(status));
          chk_field("region_count", 64'(want.count), 64'(region_count));
          chk_field("last", 64'(want.last), 64'(last));
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("boot_memory_map_parser verification failed");
    $finish;
  end

  initial begin
    int unsigned r, goal;
    walk_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // idle data, unknown action, absent structure
    push_word(bmm_pkg::ACT_DATA, 32'hFFFF_FFFF);
    push_word(2'd3, 32'hFFFF_FFFF);
    push_word(bmm_pkg::ACT_ABSENT, 32'h0000_0000);
    // header too small
    push_word(bmm_pkg::ACT_START, 32'h0000_0004);
    // end tag right after the header
    push_word(bmm_pkg::ACT_START, 32'h0000_0010);
    push_word(bmm_pkg::ACT_DATA, 32'h0000_0000);
    push_word(bmm_pkg::ACT_DATA, bmm_pkg::TYPE_END);
    // largest total, map tag running past it
    push_word(bmm_pkg::ACT_START, 32'hFFFF_FFFF);
    push_word(bmm_pkg::ACT_DATA, 32'hFFFF_FFFF);
    push_word(bmm_pkg::ACT_DATA, bmm_pkg::TYPE_MAP);
    push_word(bmm_pkg::ACT_DATA, 32'hFFFF_FFFF);
    // tag below header size
    push_word(bmm_pkg::ACT_START, 32'd32);
    push_word(bmm_pkg::ACT_DATA, 32'd0);
    push_word(bmm_pkg::ACT_DATA, 32'd1);
    push_word(bmm_pkg::ACT_DATA, 32'd4);
    // map tag below its header size
    push_word(bmm_pkg::ACT_START, 32'd32);
    push_word(bmm_pkg::ACT_DATA, 32'd0);
    push_word(bmm_pkg::ACT_DATA, bmm_pkg::TYPE_MAP);
    push_word(bmm_pkg::ACT_DATA, 32'd12);
    // entries too small
    push_word(bmm_pkg::ACT_START, 32'd64);
    push_word(bmm_pkg::ACT_DATA, 32'd0);
    push_word(bmm_pkg::ACT_DATA, bmm_pkg::TYPE_MAP);
    push_word(bmm_pkg::ACT_DATA, 32'd40);
    push_word(bmm_pkg::ACT_DATA, 32'd20);
    push_word(bmm_pkg::ACT_DATA, 32'd0);
    stim_words += 25;
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = idle_tab[ph];
      recv_stall = stall_tab[ph];
      if (ph == 0) hold_arm = 1'b1;
      goal = stim_words + 375;
      while (stim_words < goal) begin
        r = $urandom_range(99);
        if (r < 70) begin
          gen_struct(FL_NONE, 1'b0);
        end else if (r < 85) begin
          gen_struct(flaw_t'($urandom_range(FL_HDR_SMALL, FL_NO_MAP)), 1'b0);
        end else if (r < 93) begin
          gen_struct(FL_NONE, 1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) push_word(2'($urandom), $urandom);
        end
      end
      wait_drained();
    end
    repeat (20) @(posedge clk);

    $display("covered %0d words in %0d structures over four traffic phases and a long stall",
             stim_words, n_structs);
    $display("checked %0d region and %0d done results, done status codes seen %b",
             n_regions, n_dones, status_seen);
    if (errors == 0) begin
      $display("boot_memory_map_parser verification clean");
    end else begin
      $display("boot_memory_map_parser verification failed");
    end
    $finish;
  end

endmodule
